[rtl/core/stable_priority_queue_macros.svh]
// Assertion macros shared by the queue's modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(lbl, cond, expect_now, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, cond, expect_next, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error(msg);

`endif

[rtl/core/spq_pkg.sv]
`default_nettype none

package spq_pkg;

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;

  // Request action codes.
  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_POP    = 2'd1;
  localparam action_t ACT_CLEAR  = 2'd2;

  // Result status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Operation that the datapath applies to the slot row.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_POP,
    OP_CLEAR
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    logic    capture;
    logic    execute;
    op_t     op;
    status_t status;
  } spq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    action_t action;
    logic    empty;
    logic    full;
  } spq_stat_t;

endpackage

`default_nettype wire

[rtl/core/spq_request_if.sv]
`default_nettype none

interface spq_request_if #(
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  spq_pkg::action_t        action;
  logic [DATA_WIDTH-1:0]   entry_data;
  logic [PRIO_WIDTH-1:0]   entry_priority;

  modport source (output valid, action, entry_data, entry_priority, input ready);
  modport sink   (input valid, action, entry_data, entry_priority, output ready);
endinterface

`default_nettype wire

[rtl/core/spq_response_if.sv]
`default_nettype none

interface spq_response_if #(
  parameter int DATA_WIDTH = 32,
  parameter int COUNT_WIDTH = 5
);
  logic                    valid;
  logic                    ready;
  logic [DATA_WIDTH-1:0]   front_data;
  logic                    data_valid;
  logic [COUNT_WIDTH-1:0]  entry_count;
  spq_pkg::status_t        status;

  modport source (output valid, front_data, data_valid, entry_count, status, input ready);
  modport sink   (input valid, front_data, data_valid, entry_count, status, output ready);
endinterface

`default_nettype wire

[rtl/core/spq_datapath.sv]
`default_nettype none

`include "stable_priority_queue_macros.svh"

module spq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire spq_pkg::spq_cmd_t             cmd,
  output spq_pkg::spq_stat_t                 stat,
  input  wire spq_pkg::action_t              action,
  input  wire logic [DATA_WIDTH-1:0]         entry_data,
  input  wire logic [PRIO_WIDTH-1:0]         entry_priority,
  output logic [DATA_WIDTH-1:0]              front_data,
  output logic                               data_valid,
  output logic [$clog2(DEPTH+1)-1:0]         entry_count,
  output spq_pkg::status_t                   status
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // Captured request.
  action_t               act_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [PRIO_WIDTH-1:0] prio_q;

  // Sorted slot row, front at index zero, and the fill count.
  logic [DATA_WIDTH-1:0] slot_data [DEPTH];
  logic [PRIO_WIDTH-1:0] slot_prio [DEPTH];
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;

  // Per-slot compare: the slot is held and ranks at or above the new entry.
  // Because the row is sorted, this mask is a run of ones from the front.
  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] ge_prev;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CW'(i) < count) && (slot_prio[i] >= prio_q);
    end
  end

  assign ge_prev = {ge[DEPTH-2:0], 1'b1};

  // Capture the request item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q  <= action;
      data_q <= entry_data;
      prio_q <= entry_priority;
    end
  end

  assign stat.action = act_q;
  assign stat.empty  = (count == '0);
  assign stat.full   = (count == CW'(DEPTH));

  // Fill count update.
  always_comb begin
    count_next = count;
    if (cmd.execute) begin
      case (cmd.op)
        OP_INSERT: count_next = count + CW'(1);
        OP_POP:    count_next = count - CW'(1);
        OP_CLEAR:  count_next = '0;
        default:   count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Each slot keeps, takes the new entry, or shifts from a neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.execute && cmd.op == OP_INSERT && !ge[g]) begin
        if (ge_prev[g]) begin
          slot_data[g] <= data_q;
          slot_prio[g] <= prio_q;
        end else begin
          if (g > 0) begin
            slot_data[g] <= slot_data[(g > 0) ? g - 1 : 0];
            slot_prio[g] <= slot_prio[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (cmd.execute && cmd.op == OP_POP) begin
        if (g < DEPTH - 1) begin
          slot_data[g] <= slot_data[(g < DEPTH - 1) ? g + 1 : g];
          slot_prio[g] <= slot_prio[(g < DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  end

  // Result register, loaded when the operation is applied.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      front_data  <= (cmd.op == OP_POP) ? slot_data[0] : '0;
      data_valid  <= (cmd.op == OP_POP);
      entry_count <= count_next;
      status      <= cmd.status;
    end
  end

  // The fill count never passes the capacity.
  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "fill count above capacity")
  // An applied insert grows the count by one.
  `SPQ_ASSERT_NEXT(a_insert_count, cmd.execute && cmd.op == OP_INSERT,
    count == $past(count) + CW'(1), "insert did not grow the count")
  // A pop returns the entry that stood at the front.
  `SPQ_ASSERT_NEXT(a_pop_front, cmd.execute && cmd.op == OP_POP,
    data_valid && front_data == $past(slot_data[0]), "pop returned the wrong entry")

endmodule

`default_nettype wire

[rtl/core/spq_controller.sv]
`default_nettype none

`include "stable_priority_queue_macros.svh"

module spq_controller (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  input  wire spq_pkg::spq_stat_t  stat,
  output spq_pkg::spq_cmd_t        cmd
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic rsp_free;

  assign req_ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;

  // Decide the operation and its status from the captured action.
  always_comb begin
    cmd.capture = req_valid && req_ready;
    cmd.execute = (state == S_EXEC) && rsp_free;
    cmd.op      = OP_NONE;
    cmd.status  = ST_OK;
    case (stat.action)
      ACT_INSERT: begin
        if (stat.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op = OP_INSERT;
        end
      end
      ACT_POP: begin
        if (stat.empty) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.op = OP_POP;
        end
      end
      ACT_CLEAR: begin
        cmd.op = OP_CLEAR;
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.execute) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Operations are applied only from the execute state.
  `SPQ_ASSERT_NOW(a_exec_state, cmd.execute, state == S_EXEC, "execute outside its state")
  // A pop is never applied to an empty queue.
  `SPQ_ASSERT_NOW(a_pop_nonempty, cmd.execute && cmd.op == OP_POP, !stat.empty,
    "pop applied to an empty queue")
  // Every applied operation presents a result in the next cycle.
  `SPQ_ASSERT_NEXT(a_exec_result, cmd.execute, rsp_valid && state == S_IDLE,
    "applied operation left no result")

endmodule

`default_nettype wire

[rtl/core/stable_priority_queue.sv]
// Bounded priority queue of DEPTH entries kept in sorted order. An insert places
// its data after every held entry of greater or equal priority, so the largest
// priority leaves first and equal priorities leave in arrival order; a pop returns
// the front entry, a clear empties the queue, and every request item gives exactly
// one response item with the data, the entry count after the step and a status
// (pop on an empty queue and insert into a full queue are flagged and change
// nothing). An item is handled by first capturing the request and then applying
// it, when every slot compares its priority with the new entry in parallel and
// the whole row shifts at once. The request side is ready only while no item is
// in work, and a captured item waits to be applied while the previous response
// is still held on the response side. After reset the queue is empty at once;
// there is no clearing pass.
`default_nettype none

module stable_priority_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  spq_request_if.sink     request,
  spq_response_if.source  response
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .action         (request.action),
    .entry_data     (request.entry_data),
    .entry_priority (request.entry_priority),
    .front_data     (response.front_data),
    .data_valid     (response.data_valid),
    .entry_count    (response.entry_count),
    .status         (response.status)
  );

endmodule

`default_nettype wire
